>>> rtl/core/q24alu_pkg.sv
// Shared types, constants and helpers for the Q24.8 fixed-point ALU.
// No dependencies; imported by q24_8_fixed_point_alu and its testbench.
package q24alu_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 4;
  // Scaled dividend width and number of divider stages (one quotient bit each)
  localparam int NUM_W         = DATA_W + FRACTION_BITS;
  localparam int DIV_STAGES    = NUM_W;
  localparam int PROD_W        = 2 * DATA_W;
  // Pipeline registers: operand capture, simple ops, divider stages, result
  localparam int STAGES        = DIV_STAGES + 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_LT       = 4'd4,
    CMD_GT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_FROM_INT = 4'd13,
    CMD_TO_INT   = 4'd14
  } cmd_t;

  // Stage 0: captured operands with their magnitudes
  typedef struct packed {
    cmd_t               cmd;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;
    logic               neg_a;
    logic               neg_b;
  } pre_t;

  // Stage 1: simple results done, product formed, divider loaded
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic               cmp;
    logic               dz;
    logic               is_mul;
    logic               is_div;
    logic               neg_q;
    logic [DATA_W-1:0]  divisor;
    logic [NUM_W-1:0]   num;
    logic [PROD_W-1:0]  prod;
  } mid_t;

  // Divider stages: partial remainder, remaining dividend bits, quotient
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic               cmp;
    logic               dz;
    logic               is_div;
    logic               neg_q;
    logic [DATA_W-1:0]  divisor;
    logic [DATA_W-1:0]  rem;
    logic [NUM_W-1:0]   num;
    logic [DATA_W-1:0]  quo;
  } divs_t;

  // One restoring-division step: bring down a dividend bit, try subtract
  function automatic divs_t div_step(input divs_t s);
    divs_t             o;
    logic [DATA_W:0]   r;
    logic [DATA_W:0]   diff;
    o    = s;
    r    = {s.rem, s.num[NUM_W-1]};
    diff = r - {1'b0, s.divisor};
    o.num = s.num << 1;
    if (!diff[DATA_W]) begin
      o.rem = diff[DATA_W-1:0];
      o.quo = {s.quo[DATA_W-2:0], 1'b1};
    end else begin
      o.rem = r[DATA_W-1:0];
      o.quo = {s.quo[DATA_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/core/q24_8_fixed_point_alu.sv
// Q24.8 fixed-point ALU, fully pipelined with a bit-per-stage divider.
// Depends on q24alu_pkg (types, command codes, divider step).
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  in      | command, operand_a, operand_b             | in_valid/in_ready
//  out     | value, compare_true, divide_by_zero       | out_valid/out_ready
//
// One item enters per cycle while the skid slot is empty; each command passes
// through the whole Q24.8 restoring divider, one quotient bit per stage.
// Reset clears all stage valid bits and the output skid slot.
// A result refused at the output moves into a one-item skid slot; the whole
// pipeline then holds until that slot drains, so in_ready is a register.
module q24_8_fixed_point_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [q24alu_pkg::CMD_W-1:0]  command,
  input  logic signed [q24alu_pkg::DATA_W-1:0] operand_a,
  input  logic signed [q24alu_pkg::DATA_W-1:0] operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [q24alu_pkg::DATA_W-1:0] value,
  output logic                          compare_true,
  output logic                          divide_by_zero
);
  import q24alu_pkg::*;

  logic                 en;
  logic [STAGES-1:0]    vld;

  pre_t                 pre_q;
  pre_t                 pre_next;
  mid_t                 mid_q;
  mid_t                 mid_next;
  divs_t                dq [DIV_STAGES];
  divs_t                d0_in;
  logic [DATA_W-1:0]    res_value;
  logic                 res_cmp;
  logic                 res_dz;
  logic [DATA_W-1:0]    res_value_next;

  logic                 skid_valid;
  logic [DATA_W-1:0]    skid_value;
  logic                 skid_cmp;
  logic                 skid_dz;

  // Pipeline moves whenever the skid slot is empty
  assign en       = !skid_valid;
  assign in_ready = en;

  // Stage 0 input: magnitudes and signs
  always_comb begin
    pre_next.cmd   = cmd_t'(command);
    pre_next.a     = operand_a;
    pre_next.b     = operand_b;
    pre_next.neg_a = operand_a[DATA_W-1];
    pre_next.neg_b = operand_b[DATA_W-1];
    pre_next.mag_a = operand_a[DATA_W-1] ? DATA_W'(0) - operand_a : operand_a;
    pre_next.mag_b = operand_b[DATA_W-1] ? DATA_W'(0) - operand_b : operand_b;
  end

  // Stage 1 input: simple ops, comparisons, multiply, divider setup
  always_comb begin
    logic               lt;
    logic               eq;
    logic               gt;
    logic [DATA_W-1:0]  ti;
    lt = $signed(pre_q.a) < $signed(pre_q.b);
    eq = pre_q.a == pre_q.b;
    gt = !lt && !eq;
    ti = pre_q.mag_a >> FRACTION_BITS;
    mid_next.value   = '0;
    mid_next.cmp     = 1'b0;
    mid_next.dz      = 1'b0;
    mid_next.is_mul  = 1'b0;
    mid_next.is_div  = 1'b0;
    mid_next.neg_q   = pre_q.neg_a ^ pre_q.neg_b;
    mid_next.divisor = pre_q.mag_b;
    mid_next.num     = {pre_q.mag_a, {FRACTION_BITS{1'b0}}};
    mid_next.prod    = PROD_W'(pre_q.mag_a) * PROD_W'(pre_q.mag_b);
    case (pre_q.cmd)
      CMD_ADD:      mid_next.value = pre_q.a + pre_q.b;
      CMD_SUB:      mid_next.value = pre_q.a - pre_q.b;
      CMD_MUL:      mid_next.is_mul = 1'b1;
      CMD_DIV: begin
        mid_next.is_div = 1'b1;
        mid_next.dz     = pre_q.b == '0;
      end
      CMD_LT:       mid_next.cmp = lt;
      CMD_GT:       mid_next.cmp = gt;
      CMD_GE:       mid_next.cmp = !lt;
      CMD_LE:       mid_next.cmp = lt || eq;
      CMD_EQ:       mid_next.cmp = eq;
      CMD_NE:       mid_next.cmp = !eq;
      CMD_MIN:      mid_next.value = gt ? pre_q.b : pre_q.a;
      CMD_MAX:      mid_next.value = gt ? pre_q.a : pre_q.b;
      CMD_INC:      mid_next.value = pre_q.a + DATA_W'(1);
      CMD_FROM_INT: mid_next.value = pre_q.a << FRACTION_BITS;
      CMD_TO_INT:   mid_next.value = pre_q.neg_a ? DATA_W'(0) - ti : ti;
      default:      mid_next.value = '0;
    endcase
  end

  // First divider stage also finishes the multiply (rescale and sign)
  always_comb begin
    logic [DATA_W-1:0] ps;
    ps = mid_q.prod[DATA_W+FRACTION_BITS-1:FRACTION_BITS];
    d0_in.value   = mid_q.is_mul ? (mid_q.neg_q ? DATA_W'(0) - ps : ps) : mid_q.value;
    d0_in.cmp     = mid_q.cmp;
    d0_in.dz      = mid_q.dz;
    d0_in.is_div  = mid_q.is_div;
    d0_in.neg_q   = mid_q.neg_q;
    d0_in.divisor = mid_q.divisor;
    d0_in.rem     = '0;
    d0_in.num     = mid_q.num;
    d0_in.quo     = '0;
  end

  // Final stage: apply quotient sign, zero on divide by zero
  always_comb begin
    res_value_next = dq[DIV_STAGES-1].value;
    if (dq[DIV_STAGES-1].is_div) begin
      if (dq[DIV_STAGES-1].dz) begin
        res_value_next = '0;
      end else if (dq[DIV_STAGES-1].neg_q) begin
        res_value_next = DATA_W'(0) - dq[DIV_STAGES-1].quo;
      end else begin
        res_value_next = dq[DIV_STAGES-1].quo;
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // Stage payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      pre_q <= pre_next;
      mid_q <= mid_next;
      dq[0] <= div_step(d0_in);
      for (int i = 1; i < DIV_STAGES; i++) begin
        dq[i] <= div_step(dq[i-1]);
      end
      res_value <= res_value_next;
      res_cmp   <= dq[DIV_STAGES-1].cmp;
      res_dz    <= dq[DIV_STAGES-1].dz;
    end
  end

  // Skid slot catches a result refused while the pipeline advances
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[STAGES-1] && !out_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_value <= res_value;
      skid_cmp   <= res_cmp;
      skid_dz    <= res_dz;
    end
  end

  // Output select: skid first, it holds the older item
  assign out_valid      = skid_valid || vld[STAGES-1];
  assign value          = skid_valid ? skid_value : res_value;
  assign compare_true   = skid_valid ? skid_cmp : res_cmp;
  assign divide_by_zero = skid_valid ? skid_dz : res_dz;

  // Divide by zero always returns a zero value
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> value == '0)
    else $error("divide by zero with nonzero value");

  // A comparison result never comes with a divide error or a nonzero value
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> !divide_by_zero && value == '0)
    else $error("comparison result mixed with other outputs");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

>>> tb/sv/q24_8_fixed_point_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: directed corner cases,
// then random operations under several input/output idle patterns.
// Depends on q24alu_pkg and q24_8_fixed_point_alu.
module q24_8_fixed_point_alu_tb;
  import q24alu_pkg::*;

  // One operation offered to the ALU
  typedef struct {
    cmd_t               cmd;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
  } alu_op_t;

  // Predicted result, with the operation kept for messages
  typedef struct {
    alu_op_t            op;
    logic [DATA_W-1:0]  value;
    logic               cmp;
    logic               dz;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] command = '0;
  logic signed [DATA_W-1:0] operand_a = '0;
  logic signed [DATA_W-1:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic compare_true;
  logic divide_by_zero;

  alu_op_t     alu_ops_pending[$];
  alu_result_t alu_results_due[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          sink_stall_pct = 0;
  // long output hold-off: requests raised by the sequencer, served by the sink
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  q24_8_fixed_point_alu i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .compare_true   (compare_true),
    .divide_by_zero (divide_by_zero)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bit-exact model of one ALU operation
  function automatic alu_result_t compute_alu_result(input alu_op_t op);
    alu_result_t        r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] prod;
    logic [63:0]        mag;
    logic [63:0]        num;
    logic [63:0]        den;
    logic signed [DATA_W-1:0] sa;
    logic signed [DATA_W-1:0] sb;
    r.op    = op;
    r.value = '0;
    r.cmp   = 1'b0;
    r.dz    = 1'b0;
    sa = op.a;
    sb = op.b;
    wa = sa;
    wb = sb;
    case (op.cmd)
      CMD_ADD: r.value = op.a + op.b;
      CMD_SUB: r.value = op.a - op.b;
      CMD_MUL: begin
        // truncate the rescaled product toward zero
        prod = wa * wb;
        mag  = prod[63] ? -prod : prod;
        mag  = mag >> FRACTION_BITS;
        if (prod[63]) mag = -mag;
        r.value = mag[DATA_W-1:0];
      end
      CMD_DIV: begin
        if (sb == 0) begin
          r.dz = 1'b1;
        end else begin
          num = (wa < 0) ? -wa : wa;
          num = num << FRACTION_BITS;
          den = (wb < 0) ? -wb : wb;
          mag = num / den;
          if (sa[DATA_W-1] ^ sb[DATA_W-1]) mag = -mag;
          r.value = mag[DATA_W-1:0];
        end
      end
      CMD_LT: r.cmp = sa < sb;
      CMD_GT: r.cmp = sa > sb;
      CMD_GE: r.cmp = sa >= sb;
      CMD_LE: r.cmp = sa <= sb;
      CMD_EQ: r.cmp = sa == sb;
      CMD_NE: r.cmp = sa != sb;
      CMD_MIN: r.value = (sa > sb) ? op.b : op.a;
      CMD_MAX: r.value = (sa > sb) ? op.a : op.b;
      CMD_INC: r.value = op.a + 32'd1;
      CMD_FROM_INT: r.value = op.a << FRACTION_BITS;
      CMD_TO_INT: begin
        mag = (wa < 0) ? -wa : wa;
        mag = mag >> FRACTION_BITS;
        if (wa < 0) mag = -mag;
        r.value = mag[DATA_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_op(input cmd_t cmd, input logic [DATA_W-1:0] a,
                          input logic [DATA_W-1:0] b);
    alu_op_t op;
    op.cmd = cmd;
    op.a   = a;
    op.b   = b;
    alu_ops_pending.push_back(op);
  endtask

  // Mix of full-range, small, extreme and short fixed-point operands
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 5))
      0, 1: return raw;
      2: return $urandom_range(0, 4095) - 2048;
      3: begin
        case ($urandom_range(0, 6))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hffff_ffff;
          5: return 32'h0000_0100;
          default: return 32'hffff_ff00;
        endcase
      end
      default: return {{16{raw[31]}}, raw[15:0]};
    endcase
  endfunction

  task automatic queue_random_ops(input int count);
    alu_op_t op;
    for (int i = 0; i < count; i++) begin
      op.cmd = cmd_t'($urandom_range(0, 14));
      op.a   = pick_operand();
      case ($urandom_range(0, 9))
        0: op.b = op.a;
        1: op.b = '0;
        default: op.b = pick_operand();
      endcase
      alu_ops_pending.push_back(op);
    end
  endtask

  // Wait for the sender to empty its queue and every result to come back
  task automatic wait_drained();
    while (alu_ops_pending.size() != 0 || in_valid || alu_results_due.size() != 0)
      @(negedge clk);
  endtask

  // Input driver: predicts on acceptance, then offers the next item
  always @(posedge clk) begin
    alu_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        op.cmd = cmd_t'(command);
        op.a   = operand_a;
        op.b   = operand_b;
        alu_results_due.push_back(compute_alu_result(op));
      end
      if (!in_valid || in_ready) begin
        if (alu_ops_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          op = alu_ops_pending.pop_front();
          in_valid  <= 1'b1;
          command   <= op.cmd;
          operand_a <= op.a;
          operand_b <= op.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = 200;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (alu_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h cmp=%b dz=%b",
                                  value, compare_true, divide_by_zero));
      end else begin
        exp_r = alu_results_due.pop_front();
        if (value !== exp_r.value)
          report_mismatch($sformatf("%s a=%h b=%h: value %h, predicted %h",
                                    exp_r.op.cmd.name(), exp_r.op.a, exp_r.op.b,
                                    value, exp_r.value));
        if (compare_true !== exp_r.cmp)
          report_mismatch($sformatf("%s a=%h b=%h: compare_true %b, predicted %b",
                                    exp_r.op.cmd.name(), exp_r.op.a, exp_r.op.b,
                                    compare_true, exp_r.cmp));
        if (divide_by_zero !== exp_r.dz)
          report_mismatch($sformatf("%s a=%h b=%h: divide_by_zero %b, predicted %b",
                                    exp_r.op.cmd.name(), exp_r.op.a, exp_r.op.b,
                                    divide_by_zero, exp_r.dz));
      end
    end
  end

  // Sequencer: reset, directed corners, then random phases
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: wrap, rounding toward zero, divide by zero, compare ties
    queue_op(CMD_ADD, 32'h7fff_ffff, 32'h0000_0001);
    queue_op(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    queue_op(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_op(CMD_MUL, 32'hffff_fed4, 32'h0000_0001);
    queue_op(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
    queue_op(CMD_DIV, 32'h0000_0100, 32'h0000_0000);
    queue_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    queue_op(CMD_DIV, 32'h7fff_ffff, 32'h0000_0001);
    queue_op(CMD_DIV, 32'h0000_0001, 32'h7fff_ffff);
    queue_op(CMD_DIV, 32'hffff_fd00, 32'h0000_0200);
    queue_op(CMD_LT,  32'h8000_0000, 32'h7fff_ffff);
    queue_op(CMD_GT,  32'h8000_0000, 32'h7fff_ffff);
    queue_op(CMD_GE,  32'h1234_5678, 32'h1234_5678);
    queue_op(CMD_LE,  32'h0000_0001, 32'hffff_ffff);
    queue_op(CMD_EQ,  32'h1234_5678, 32'h1234_5678);
    queue_op(CMD_NE,  32'h1234_5678, 32'h1234_5678);
    queue_op(CMD_EQ,  32'h0000_0000, 32'h8000_0000);
    queue_op(CMD_MIN, 32'h8000_0000, 32'h7fff_ffff);
    queue_op(CMD_MAX, 32'h8000_0000, 32'h7fff_ffff);
    queue_op(CMD_INC, 32'h7fff_ffff, 32'hffff_ffff);
    queue_op(CMD_FROM_INT, 32'h00ff_ffff, 32'h0000_0000);
    queue_op(CMD_FROM_INT, 32'h8000_0001, 32'h0000_0000);
    queue_op(CMD_TO_INT, 32'hffff_ffff, 32'h0000_0000);
    queue_op(CMD_TO_INT, 32'hffff_feff, 32'h7fff_ffff);
    wait_drained();

    // no idling, with a long output hold-off so the pipeline backs up
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    queue_random_ops(100);
    repeat (10) @(negedge clk);
    hold_requests++;
    wait_drained();

    // sparse input
    send_idle_pct  = 80;
    sink_stall_pct = 0;
    queue_random_ops(100);
    wait_drained();

    // heavy output back-pressure
    send_idle_pct  = 0;
    sink_stall_pct = 80;
    queue_random_ops(100);
    wait_drained();

    // light idling on both sides
    send_idle_pct  = 12;
    sink_stall_pct = 12;
    queue_random_ops(100);
    wait_drained();

    // let any stray result show up
    repeat (2 * (NUM_W + 3) + 4) @(posedge clk);
    if (error_count == 0 && alu_results_due.size() == 0) begin
      $display("q24_8_fixed_point_alu_tb: done, clean");
    end else begin
      $display("q24_8_fixed_point_alu_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 200000);
    $display("q24_8_fixed_point_alu_tb: done, errors");
    $finish;
  end

endmodule
